// ===== hdl/kvmt_pkg.sv =====
package kvmt_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ChEq  = 8'h3D;
  localparam logic [ByteW-1:0] ChAmp = 8'h26;
  localparam logic [ByteW-1:0] ChNul = 8'h00;
  localparam logic [ByteW-1:0] ChLf  = 8'h0A;
  localparam logic [ByteW-1:0] ChCr  = 8'h0D;

  typedef enum logic [3:0] {
    PH_KEY_START = 4'b0001,
    PH_IN_KEY    = 4'b0010,
    PH_IN_VALUE  = 4'b0100,
    PH_SKIP      = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_KEY   = 2'd0,
    ROLE_VALUE = 2'd1,
    ROLE_SEP   = 2'd2,
    ROLE_OTHER = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_KEY_NO_VALUE = 2'd1,
    ST_STRAY_EQ     = 2'd2
  } status_e;

  function automatic logic is_term(input logic [ByteW-1:0] c);
    return (c == ChNul) || (c == ChLf) || (c == ChCr);
  endfunction

endpackage

// ===== hdl/key_value_message_tokenizer.sv =====
// Each accepted input beat goes into the input register, is classified, and
//   updates the parse state as it moves into the result register (out_valid_o).
// Throughput: one byte per cycle unless out_stall_i stalls the output.
// Reset (rst_ni low, asynchronous): parse phase returns to key start, pending
//   error to ok, and both pipeline stages empty.
module key_value_message_tokenizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kvmt_pkg::ByteW-1:0]  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kvmt_pkg::ByteW-1:0]  out_byte_o,
  output logic [1:0]                  role_o,
  output logic                        pair_done_o,
  output logic                        message_done_o,
  output logic [1:0]                  status_o
);

  logic                       s1_valid_q, s1_valid_d;
  logic [kvmt_pkg::ByteW-1:0] s1_byte_q;

  kvmt_pkg::phase_e  phase_q, phase_d;
  kvmt_pkg::status_e err_q, err_d;

  logic                       out_valid_q, out_valid_d;
  logic [kvmt_pkg::ByteW-1:0] out_byte_q;
  kvmt_pkg::role_e            role_q, role_d;
  logic                       pdone_q, pdone_d;
  logic                       mdone_q, mdone_d;
  kvmt_pkg::status_e          st_q, st_d;

  logic out_free;
  logic s1_adv;
  logic in_acc;
  logic term, is_eq, is_amp;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc || (s1_valid_q && !out_free);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  assign term   = kvmt_pkg::is_term(s1_byte_q);
  assign is_eq  = (s1_byte_q == kvmt_pkg::ChEq);
  assign is_amp = (s1_byte_q == kvmt_pkg::ChAmp);

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    role_d  = kvmt_pkg::ROLE_OTHER;
    pdone_d = 1'b0;
    mdone_d = 1'b0;
    st_d    = kvmt_pkg::ST_OK;
    case (phase_q)
      kvmt_pkg::PH_KEY_START, kvmt_pkg::PH_IN_KEY: begin
        if (term) begin
          mdone_d = 1'b1;
          st_d    = (phase_q == kvmt_pkg::PH_KEY_START) ? kvmt_pkg::ST_OK
                                                        : kvmt_pkg::ST_KEY_NO_VALUE;
          phase_d = kvmt_pkg::PH_KEY_START;
          err_d   = kvmt_pkg::ST_OK;
        end else if (is_eq) begin
          role_d  = kvmt_pkg::ROLE_SEP;
          phase_d = kvmt_pkg::PH_IN_VALUE;
        end else if (is_amp) begin
          err_d   = kvmt_pkg::ST_KEY_NO_VALUE;
          phase_d = kvmt_pkg::PH_SKIP;
        end else begin
          role_d  = kvmt_pkg::ROLE_KEY;
          phase_d = kvmt_pkg::PH_IN_KEY;
        end
      end
      kvmt_pkg::PH_IN_VALUE: begin
        if (term) begin
          pdone_d = 1'b1;
          mdone_d = 1'b1;
          phase_d = kvmt_pkg::PH_KEY_START;
          err_d   = kvmt_pkg::ST_OK;
        end else if (is_amp) begin
          role_d  = kvmt_pkg::ROLE_SEP;
          pdone_d = 1'b1;
          phase_d = kvmt_pkg::PH_KEY_START;
        end else if (is_eq) begin
          err_d   = kvmt_pkg::ST_STRAY_EQ;
          phase_d = kvmt_pkg::PH_SKIP;
        end else begin
          role_d  = kvmt_pkg::ROLE_VALUE;
        end
      end
      default: begin
        if (term) begin
          mdone_d = 1'b1;
          st_d    = err_q;
          phase_d = kvmt_pkg::PH_KEY_START;
          err_d   = kvmt_pkg::ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= kvmt_pkg::PH_KEY_START;
      err_q       <= kvmt_pkg::ST_OK;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        phase_q <= phase_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_byte_i;
    end
    if (s1_adv) begin
      out_byte_q <= s1_byte_q;
      role_q     <= role_d;
      pdone_q    <= pdone_d;
      mdone_q    <= mdone_d;
      st_q       <= st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign role_o         = role_q;
  assign pair_done_o    = pdone_q;
  assign message_done_o = mdone_q;
  assign status_o       = st_q;

  // pending error only lives while skipping
  a_err_only_in_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != kvmt_pkg::ST_OK) |-> (phase_q == kvmt_pkg::PH_SKIP))
    else $error("pending error outside skip phase");

  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !message_done_o) |-> (status_o == kvmt_pkg::ST_OK))
    else $error("status set without message_done");

  a_pair_done_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pair_done_o) |->
      (role_o == kvmt_pkg::ROLE_SEP || role_o == kvmt_pkg::ROLE_OTHER))
    else $error("pair_done on a key or value byte");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (s1_valid_q && $stable(s1_byte_q) && $stable(phase_q)))
    else $error("input stage lost a beat under stall");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

typedef struct packed {
  logic [kvmt_pkg::ByteW-1:0] out_byte;
  kvmt_pkg::role_e            role;
  logic                       pair_done;
  logic                       message_done;
  kvmt_pkg::status_e          status;
} byte_tag_t;

class token_scoreboard;
  kvmt_pkg::phase_e  phase;
  kvmt_pkg::status_e pending_err;
  byte_tag_t         expected_tags[$];
  int unsigned       errors;

  function new();
    phase       = kvmt_pkg::PH_KEY_START;
    pending_err = kvmt_pkg::ST_OK;
    errors      = 0;
  endfunction

  function int unsigned pending();
    return expected_tags.size();
  endfunction

  // Classify one accepted byte and advance the parse state.
  function void note_byte(logic [kvmt_pkg::ByteW-1:0] c);
    byte_tag_t t;
    logic      term;
    term           = (c == kvmt_pkg::ChNul) || (c == kvmt_pkg::ChLf) || (c == kvmt_pkg::ChCr);
    t.out_byte     = c;
    t.role         = kvmt_pkg::ROLE_OTHER;
    t.pair_done    = 1'b0;
    t.message_done = 1'b0;
    t.status       = kvmt_pkg::ST_OK;
    case (phase)
      kvmt_pkg::PH_KEY_START, kvmt_pkg::PH_IN_KEY: begin
        if (term) begin
          t.message_done = 1'b1;
          t.status       = (phase == kvmt_pkg::PH_KEY_START) ? kvmt_pkg::ST_OK
                                                             : kvmt_pkg::ST_KEY_NO_VALUE;
          phase          = kvmt_pkg::PH_KEY_START;
          pending_err    = kvmt_pkg::ST_OK;
        end else if (c == kvmt_pkg::ChEq) begin
          t.role = kvmt_pkg::ROLE_SEP;
          phase  = kvmt_pkg::PH_IN_VALUE;
        end else if (c == kvmt_pkg::ChAmp) begin
          pending_err = kvmt_pkg::ST_KEY_NO_VALUE;
          phase       = kvmt_pkg::PH_SKIP;
        end else begin
          t.role = kvmt_pkg::ROLE_KEY;
          phase  = kvmt_pkg::PH_IN_KEY;
        end
      end
      kvmt_pkg::PH_IN_VALUE: begin
        if (term) begin
          t.pair_done    = 1'b1;
          t.message_done = 1'b1;
          phase          = kvmt_pkg::PH_KEY_START;
          pending_err    = kvmt_pkg::ST_OK;
        end else if (c == kvmt_pkg::ChAmp) begin
          t.role      = kvmt_pkg::ROLE_SEP;
          t.pair_done = 1'b1;
          phase       = kvmt_pkg::PH_KEY_START;
        end else if (c == kvmt_pkg::ChEq) begin
          pending_err = kvmt_pkg::ST_STRAY_EQ;
          phase       = kvmt_pkg::PH_SKIP;
        end else begin
          t.role = kvmt_pkg::ROLE_VALUE;
        end
      end
      default: begin
        if (term) begin
          t.message_done = 1'b1;
          t.status       = pending_err;
          phase          = kvmt_pkg::PH_KEY_START;
          pending_err    = kvmt_pkg::ST_OK;
        end
      end
    endcase
    expected_tags.insert(expected_tags.size(), t);
  endfunction

  function void cmp(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_tag(logic [kvmt_pkg::ByteW-1:0] b, logic [1:0] role, logic pd,
                          logic md, logic [1:0] st);
    byte_tag_t t;
    if (expected_tags.size() == 0) begin
      $display("%0t: unexpected result beat, expected none actual byte %0d", $time, b);
      errors++;
      return;
    end
    t = expected_tags.pop_front();
    cmp("out_byte", t.out_byte, b);
    cmp("role", t.role, role);
    cmp("pair_done", t.pair_done, pd);
    cmp("message_done", t.message_done, md);
    cmp("status", t.status, st);
  endfunction
endclass

module testbench;

  typedef logic [kvmt_pkg::ByteW-1:0] byte_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 1400;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  byte_t      in_byte_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  byte_t      out_byte_o;
  logic [1:0] role_o;
  logic       pair_done_o;
  logic       message_done_o;
  logic [1:0] status_o;

  token_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     sent_count  = 0;
  int unsigned     stall_left  = 0;
  bit              idle_on     = 1'b1;

  always #5 clk_i = ~clk_i;

  key_value_message_tokenizer i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_byte_i,
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .role_o,
    .pair_done_o,
    .message_done_o,
    .status_o
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** key_value_message_tokenizer: FAILED **");
      $finish;
    end
    if (in_valid_i && !in_stall_o) begin
      sb.note_byte(in_byte_i);
    end
    if (out_valid_o && !out_stall_i) begin
      sb.check_tag(out_byte_o, role_o, pair_done_o, message_done_o, status_o);
      stall_left = idle_on ? $urandom_range(0, 9) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(byte_t b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_count++;
  endtask

  function automatic byte_t plain_byte();
    byte_t v;
    do begin
      v = byte_t'($urandom_range(0, 255));
    end while (v == kvmt_pkg::ChEq || v == kvmt_pkg::ChAmp || v == kvmt_pkg::ChNul ||
               v == kvmt_pkg::ChLf || v == kvmt_pkg::ChCr);
    return v;
  endfunction

  function automatic byte_t term_byte();
    case ($urandom_range(0, 2))
      0:       return kvmt_pkg::ChNul;
      1:       return kvmt_pkg::ChLf;
      default: return kvmt_pkg::ChCr;
    endcase
  endfunction

  task automatic send_message();
    int unsigned kind;
    int unsigned pairs;
    kind  = $urandom_range(0, 9);
    pairs = $urandom_range(0, 4);
    if (kind < 7) begin
      for (int unsigned p = 0; p < pairs; p++) begin
        if (p > 0) send_beat(kvmt_pkg::ChAmp);
        repeat ($urandom_range(0, 4)) send_beat(plain_byte());
        send_beat(kvmt_pkg::ChEq);
        repeat ($urandom_range(0, 4)) send_beat(plain_byte());
      end
      if ($urandom_range(0, 7) == 0) send_beat(kvmt_pkg::ChAmp);
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 5))
          0:       send_beat(kvmt_pkg::ChEq);
          1:       send_beat(kvmt_pkg::ChAmp);
          default: send_beat(plain_byte());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) send_beat(byte_t'($urandom_range(0, 255)));
    end
    send_beat(term_byte());
  endtask

  initial begin
    byte_t directed_q[$] = '{
      kvmt_pkg::ChNul,
      kvmt_pkg::ChEq, 8'hFF, kvmt_pkg::ChAmp, kvmt_pkg::ChLf,
      8'h01, kvmt_pkg::ChEq, kvmt_pkg::ChCr,
      8'h6B, kvmt_pkg::ChEq, kvmt_pkg::ChAmp, kvmt_pkg::ChEq, 8'h76, kvmt_pkg::ChEq,
      8'h78, kvmt_pkg::ChNul,
      8'h71, kvmt_pkg::ChAmp, 8'h72, kvmt_pkg::ChCr,
      8'h61, 8'hFE, kvmt_pkg::ChLf,
      kvmt_pkg::ChAmp, kvmt_pkg::ChNul
    };
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_q[i]) send_beat(directed_q[i]);
    while (sent_count < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) idle_on = ~idle_on;
      send_message();
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b1;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** key_value_message_tokenizer: PASSED **");
    end else begin
      $display("** key_value_message_tokenizer: FAILED **");
    end
    $finish;
  end
endmodule
